[hdl/complex_sample_alu_assert.svh]
// assertion macros used by the complex sample alu top level
`ifndef COMPLEX_SAMPLE_ALU_ASSERT_SVH
`define COMPLEX_SAMPLE_ALU_ASSERT_SVH

// condition and consequence checked in the same cycle
`define CSA_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("csa assertion failed (same cycle)");

// consequence checked in the cycle after the condition
`define CSA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("csa assertion failed (next cycle)");

`endif

[hdl/csa_pkg.sv]
// shared constants, types and codes for the complex sample alu
package csa_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COEFF_BITS    = 18;
  localparam int SAMPLE_FRAC   = SAMPLE_BITS - 1;
  localparam int COEFF_FRAC    = COEFF_BITS - 3;
  localparam int FUNC_BITS     = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COEFF_BITS;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // 1.0 in coefficient format
  localparam logic signed [COEFF_BITS-1:0] COEFF_ONE =
    {{(COEFF_BITS-1){1'b0}}, 1'b1} << COEFF_FRAC;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_CONJ  = 0,
    FN_MUL   = 1,
    FN_SCALE = 2,
    FN_SUB   = 3,
    FN_ADD   = 4,
    FN_LIN   = 5,
    FN_CMUL  = 6
  } func_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCALE    = 0,
    CFG_LAMBDA   = 1,
    CFG_MU       = 2,
    CFG_CONST_RE = 3,
    CFG_CONST_IM = 4
  } cfg_idx_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEFF_BITS-1:0]  coeff_t;

  typedef struct packed {
    coeff_t scale;
    coeff_t lambda;
    coeff_t mu;
    coeff_t c_re;
    coeff_t c_im;
  } csa_coeffs_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    sample_t              a_re;
    sample_t              a_im;
    sample_t              b_re;
    sample_t              b_im;
  } csa_item_t;

  typedef struct packed {
    sample_t y_re;
    sample_t y_im;
    logic    saturated;
  } csa_result_t;

endpackage

[hdl/csa_in_if.sv]
// request channel carrying an operation code and two complex samples
interface csa_in_if import csa_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [FUNC_BITS-1:0] func;
  sample_t              a_re;
  sample_t              a_im;
  sample_t              b_re;
  sample_t              b_im;

  modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

[hdl/csa_out_if.sv]
// result channel carrying one complex sample and the saturation flag
interface csa_out_if import csa_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t y_re;
  sample_t y_im;
  logic    saturated;

  modport source (output valid, y_re, y_im, saturated, input ready);
  modport sink   (input valid, y_re, y_im, saturated, output ready);
endinterface

[hdl/complex_sample_alu.sv]
// top level of the complex sample alu: request and result registers around the core
//
//  channel   dir  handshake        payload
//  in_chan   in   valid / ready    func, a_re, a_im, b_re, b_im
//  out_chan  out  valid / ready    y_re, y_im, saturated
//  cfg_*     in   cfg_wr_en only   cfg_idx, cfg_wdata (five coefficient registers)
//
//  one request per cycle sustained while out_chan is ready; a result is offered
//  after its request passes the request register, then the result register behind
//  the multiply stage, which is the four multipliers plus round and clip
//  reset (rst_n low at a clock edge) empties both stages and restores coefficients
//  a stalled result holds; the request stage still takes a new request while empty
`include "complex_sample_alu_assert.svh"
module complex_sample_alu import csa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  csa_in_if.sink                   in_chan,
  csa_out_if.source                out_chan,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  csa_coeffs_t coeffs;
  csa_result_t core_res;

  // request stage
  logic        req_vld_r, req_vld_nxt;
  csa_item_t   req_r, req_nxt;
  // result stage
  logic        res_vld_r, res_vld_nxt;
  csa_result_t res_r, res_nxt;

  logic in_fire, out_fire, req_adv;

  csa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .coeffs    (coeffs)
  );

  csa_core u_core (
    .item   (req_r),
    .coeffs (coeffs),
    .result (core_res)
  );

  // the request stage moves on when the result register is free or being drained
  assign req_adv        = !res_vld_r || out_chan.ready;
  assign in_chan.ready  = !req_vld_r || req_adv;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_fire       = out_chan.valid && out_chan.ready;

  always_comb begin
    req_nxt     = req_r;
    req_vld_nxt = req_vld_r;
    if (in_fire) begin
      req_nxt.func = in_chan.func;
      req_nxt.a_re = in_chan.a_re;
      req_nxt.a_im = in_chan.a_im;
      req_nxt.b_re = in_chan.b_re;
      req_nxt.b_im = in_chan.b_im;
      req_vld_nxt  = 1'b1;
    end else if (req_adv) begin
      req_vld_nxt  = 1'b0;
    end
  end

  always_comb begin
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r;
    if (req_adv) begin
      res_vld_nxt = req_vld_r;
      if (req_vld_r) begin
        res_nxt = core_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  assign out_chan.valid     = res_vld_r;
  assign out_chan.y_re      = res_r.y_re;
  assign out_chan.y_im      = res_r.y_im;
  assign out_chan.saturated = res_r.saturated;

  // a taken request always lands in the request stage
  `CSA_ASSERT_NEXT(a_req_loaded, clk, rst_n, in_fire, req_vld_r)
  // a full request stage that moves on fills the result stage
  `CSA_ASSERT_NEXT(a_res_loaded, clk, rst_n, req_vld_r && req_adv, res_vld_r)
  // a delivered result with nothing behind it leaves the result stage empty
  `CSA_ASSERT_NEXT(a_res_drained, clk, rst_n, out_fire && !req_vld_r, !res_vld_r)
  // a saturated result sits at an end of the sample range
  `CSA_ASSERT_SAME(a_sat_at_limit, clk, rst_n, res_vld_r && res_r.saturated,
    res_r.y_re == SAMPLE_MAX || res_r.y_re == SAMPLE_MIN ||
    res_r.y_im == SAMPLE_MAX || res_r.y_im == SAMPLE_MIN)

endmodule

[hdl/csa_cfg_regs.sv]
// coefficient register bank written through the configuration port
module csa_cfg_regs import csa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output csa_coeffs_t              coeffs
);

  csa_coeffs_t coeffs_r;
  csa_coeffs_t coeffs_nxt;

  always_comb begin
    coeffs_nxt = coeffs_r;
    if (cfg_wr_en) begin
      case (cfg_idx)
        CFG_SCALE:    coeffs_nxt.scale  = cfg_wdata;
        CFG_LAMBDA:   coeffs_nxt.lambda = cfg_wdata;
        CFG_MU:       coeffs_nxt.mu     = cfg_wdata;
        CFG_CONST_RE: coeffs_nxt.c_re   = cfg_wdata;
        CFG_CONST_IM: coeffs_nxt.c_im   = cfg_wdata;
        default:      coeffs_nxt        = coeffs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeffs_r.scale  <= COEFF_ONE;
      coeffs_r.lambda <= COEFF_ONE;
      coeffs_r.mu     <= COEFF_ONE;
      coeffs_r.c_re   <= COEFF_ONE;
      coeffs_r.c_im   <= '0;
    end else begin
      coeffs_r <= coeffs_nxt;
    end
  end

  assign coeffs = coeffs_r;

endmodule

[hdl/csa_core.sv]
// four multipliers, add/subtract, rounding and saturation for one item
module csa_core import csa_pkg::*; (
  input  csa_item_t   item,
  input  csa_coeffs_t coeffs,
  output csa_result_t result
);

  localparam int MUL_W  = (COEFF_BITS > SAMPLE_BITS) ? COEFF_BITS : SAMPLE_BITS;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W + 1;

  localparam logic signed [RND_W-1:0] HALF_S = {{(RND_W-1){1'b0}}, 1'b1} << (SAMPLE_FRAC - 1);
  localparam logic signed [RND_W-1:0] HALF_C = {{(RND_W-1){1'b0}}, 1'b1} << (COEFF_FRAC - 1);
  localparam logic signed [RND_W-1:0] MAX_W  = RND_W'(SAMPLE_MAX);
  localparam logic signed [RND_W-1:0] MIN_W  = RND_W'(SAMPLE_MIN);

  typedef enum logic [1:0] {RM_EXACT, RM_SAMPLE, RM_COEFF} rnd_mode_t;

  logic signed [MUL_W-1:0]  x0, x1, x2, x3;
  logic signed [MUL_W-1:0]  c0, c1, c2, c3;
  logic signed [PROD_W-1:0] p0, p1, p2, p3;
  logic signed [SUM_W-1:0]  re_ps, im_ps;
  logic signed [RND_W-1:0]  re_rs, im_rs, re_rc, im_rc;
  logic signed [RND_W-1:0]  exact_re, exact_im, val_re, val_im;
  logic                     sub_re;
  rnd_mode_t                mode;
  logic                     sat_re, sat_im;

  // operand routing per operation
  always_comb begin
    x0 = '0; x1 = '0; x2 = '0; x3 = '0;
    c0 = '0; c1 = '0; c2 = '0; c3 = '0;
    sub_re   = 1'b0;
    mode     = RM_EXACT;
    exact_re = '0;
    exact_im = '0;
    case (item.func)
      FN_CONJ: begin
        exact_re = RND_W'(item.a_re);
        exact_im = -RND_W'(item.a_im);
      end
      FN_MUL: begin
        x0 = MUL_W'(item.a_re); c0 = MUL_W'(item.b_re);
        x1 = MUL_W'(item.a_im); c1 = MUL_W'(item.b_im);
        x2 = MUL_W'(item.a_re); c2 = MUL_W'(item.b_im);
        x3 = MUL_W'(item.a_im); c3 = MUL_W'(item.b_re);
        sub_re = 1'b1;
        mode   = RM_SAMPLE;
      end
      FN_SCALE: begin
        x0 = MUL_W'(item.a_re); c0 = MUL_W'(coeffs.scale);
        x2 = MUL_W'(item.a_im); c2 = MUL_W'(coeffs.scale);
        mode = RM_COEFF;
      end
      FN_SUB: begin
        exact_re = RND_W'(item.a_re) - RND_W'(item.b_re);
        exact_im = RND_W'(item.a_im) - RND_W'(item.b_im);
      end
      FN_ADD: begin
        exact_re = RND_W'(item.a_re) + RND_W'(item.b_re);
        exact_im = RND_W'(item.a_im) + RND_W'(item.b_im);
      end
      FN_LIN: begin
        x0 = MUL_W'(item.a_re); c0 = MUL_W'(coeffs.lambda);
        x1 = MUL_W'(item.b_re); c1 = MUL_W'(coeffs.mu);
        x2 = MUL_W'(item.a_im); c2 = MUL_W'(coeffs.lambda);
        x3 = MUL_W'(item.b_im); c3 = MUL_W'(coeffs.mu);
        mode = RM_COEFF;
      end
      FN_CMUL: begin
        x0 = MUL_W'(item.a_re); c0 = MUL_W'(coeffs.c_re);
        x1 = MUL_W'(item.a_im); c1 = MUL_W'(coeffs.c_im);
        x2 = MUL_W'(item.a_re); c2 = MUL_W'(coeffs.c_im);
        x3 = MUL_W'(item.a_im); c3 = MUL_W'(coeffs.c_re);
        sub_re = 1'b1;
        mode   = RM_COEFF;
      end
      default: begin
        mode = RM_EXACT;
      end
    endcase
  end

  assign p0 = x0 * c0;
  assign p1 = x1 * c1;
  assign p2 = x2 * c2;
  assign p3 = x3 * c3;

  assign re_ps = sub_re ? (SUM_W'(p0) - SUM_W'(p1)) : (SUM_W'(p0) + SUM_W'(p1));
  assign im_ps = SUM_W'(p2) + SUM_W'(p3);

  // round half up, then arithmetic shift
  assign re_rs = (RND_W'(re_ps) + HALF_S) >>> SAMPLE_FRAC;
  assign im_rs = (RND_W'(im_ps) + HALF_S) >>> SAMPLE_FRAC;
  assign re_rc = (RND_W'(re_ps) + HALF_C) >>> COEFF_FRAC;
  assign im_rc = (RND_W'(im_ps) + HALF_C) >>> COEFF_FRAC;

  always_comb begin
    case (mode)
      RM_SAMPLE: begin val_re = re_rs;    val_im = im_rs;    end
      RM_COEFF:  begin val_re = re_rc;    val_im = im_rc;    end
      default:   begin val_re = exact_re; val_im = exact_im; end
    endcase
  end

  // clip to the sample range
  always_comb begin
    sat_re = 1'b0;
    sat_im = 1'b0;
    if (val_re > MAX_W) begin
      result.y_re = SAMPLE_MAX; sat_re = 1'b1;
    end else if (val_re < MIN_W) begin
      result.y_re = SAMPLE_MIN; sat_re = 1'b1;
    end else begin
      result.y_re = SAMPLE_BITS'(val_re);
    end
    if (val_im > MAX_W) begin
      result.y_im = SAMPLE_MAX; sat_im = 1'b1;
    end else if (val_im < MIN_W) begin
      result.y_im = SAMPLE_MIN; sat_im = 1'b1;
    end else begin
      result.y_im = SAMPLE_BITS'(val_im);
    end
    result.saturated = sat_re | sat_im;
  end

endmodule

[dv/testbench.sv]
// self-checking testbench for the complex sample alu: driver, monitor and predictor
module testbench import csa_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // the 3-bit opcode field leaves one code unused; the block answers it with zeros
  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 3'd7;
  localparam coeff_t COEFF_MAX = {1'b0, {(COEFF_BITS-1){1'b1}}};
  localparam coeff_t COEFF_MIN = {1'b1, {(COEFF_BITS-1){1'b0}}};
  localparam coeff_t COEFF_NEG_ONE = -COEFF_ONE;
  // time for the last result to pass through the block, with some margin
  localparam int DRAIN_CYCLES = 4;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  csa_in_if  req_chan ();
  csa_out_if res_chan ();

  complex_sample_alu dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_chan),
    .out_chan  (res_chan),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // requests waiting to be driven, and results predicted for accepted requests
  csa_item_t   request_queue[$];
  csa_result_t expected_results[$];
  // testbench copy of the coefficient registers
  csa_coeffs_t coeff_regs;

  int error_count     = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int saturated_seen  = 0;
  int settings_used   = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // add half an lsb, then drop the fraction bits (arithmetic shift floors)
  function automatic longint round_frac(input longint p, input int frac_bits);
    return (p + (longint'(1) <<< (frac_bits - 1))) >>> frac_bits;
  endfunction

  // clip to the sample range, flagging any clipping
  function automatic sample_t clip_sample(input longint v, inout logic clipped);
    longint hi;
    longint lo;
    hi = longint'(SAMPLE_MAX);
    lo = longint'(SAMPLE_MIN);
    if (v > hi) begin
      clipped = 1'b1;
      return SAMPLE_MAX;
    end
    if (v < lo) begin
      clipped = 1'b1;
      return SAMPLE_MIN;
    end
    return sample_t'(v);
  endfunction

  function automatic csa_result_t alu_result(input csa_item_t it, input csa_coeffs_t k);
    longint ar, ai, br, bi, yr, yi;
    longint k_scale, k_lambda, k_mu, k_re, k_im;
    logic clipped;
    csa_result_t r;
    ar = longint'($signed(it.a_re));
    ai = longint'($signed(it.a_im));
    br = longint'($signed(it.b_re));
    bi = longint'($signed(it.b_im));
    k_scale  = longint'($signed(k.scale));
    k_lambda = longint'($signed(k.lambda));
    k_mu     = longint'($signed(k.mu));
    k_re     = longint'($signed(k.c_re));
    k_im     = longint'($signed(k.c_im));
    yr = 0;
    yi = 0;
    clipped = 1'b0;
    case (it.func)
      FN_CONJ: begin
        yr = ar;
        yi = -ai;
      end
      FN_MUL: begin
        yr = round_frac(ar * br - ai * bi, SAMPLE_FRAC);
        yi = round_frac(ar * bi + ai * br, SAMPLE_FRAC);
      end
      FN_SCALE: begin
        yr = round_frac(k_scale * ar, COEFF_FRAC);
        yi = round_frac(k_scale * ai, COEFF_FRAC);
      end
      FN_SUB: begin
        yr = ar - br;
        yi = ai - bi;
      end
      FN_ADD: begin
        yr = ar + br;
        yi = ai + bi;
      end
      FN_LIN: begin
        yr = round_frac(k_lambda * ar + k_mu * br, COEFF_FRAC);
        yi = round_frac(k_lambda * ai + k_mu * bi, COEFF_FRAC);
      end
      FN_CMUL: begin
        yr = round_frac(k_re * ar - k_im * ai, COEFF_FRAC);
        yi = round_frac(k_im * ar + k_re * ai, COEFF_FRAC);
      end
      default: begin
        // unused opcode: zero result, no flag
        yr = 0;
        yi = 0;
      end
    endcase
    r.y_re      = clip_sample(yr, clipped);
    r.y_im      = clip_sample(yi, clipped);
    r.saturated = clipped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic csa_item_t make_item(input logic [FUNC_BITS-1:0] f,
                                          input sample_t ar, input sample_t ai,
                                          input sample_t br, input sample_t bi);
    csa_item_t it;
    it.func = f;
    it.a_re = ar;
    it.a_im = ai;
    it.b_re = br;
    it.b_im = bi;
    return it;
  endfunction

  // samples weighted towards the range ends, where clipping and rounding bite
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 11))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return sample_t'($signed($urandom_range(0, 4)) - 2);
      4:       return sample_t'($urandom_range(0, 255));
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic coeff_t pick_coeff();
    case ($urandom_range(0, 9))
      0:       return COEFF_MAX;
      1:       return COEFF_MIN;
      2:       return '0;
      3:       return COEFF_ONE;
      4:       return COEFF_NEG_ONE;
      default: return coeff_t'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int count);
    for (int n = 0; n < count; n++) begin
      request_queue.push_back(make_item(FUNC_BITS'($urandom_range(0, 7)),
                                        pick_sample(), pick_sample(),
                                        pick_sample(), pick_sample()));
    end
  endtask

  // register writes happen back to back; apply_coeffs drops the enable in the cycle after the last
  task automatic write_coeff(input cfg_idx_t idx, input coeff_t value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_SCALE:    coeff_regs.scale  = value;
      CFG_LAMBDA:   coeff_regs.lambda = value;
      CFG_MU:       coeff_regs.mu     = value;
      CFG_CONST_RE: coeff_regs.c_re   = value;
      CFG_CONST_IM: coeff_regs.c_im   = value;
      default: ;
    endcase
  endtask

  task automatic apply_coeffs(input coeff_t s, input coeff_t l, input coeff_t m,
                              input coeff_t cr, input coeff_t ci);
    write_coeff(CFG_SCALE, s);
    write_coeff(CFG_LAMBDA, l);
    write_coeff(CFG_MU, m);
    write_coeff(CFG_CONST_RE, cr);
    write_coeff(CFG_CONST_IM, ci);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // block is idle once nothing is queued, presented or outstanding
  // (checked mid-cycle, after the driver's updates have settled)
  task automatic wait_idle();
    while (request_queue.size() != 0 || req_chan.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : request_driver
    csa_item_t shown;
    csa_item_t next_req;
    logic      next_valid;
    logic      load;
    if (!rst_n) begin
      req_chan.valid <= 1'b0;
      req_chan.func  <= '0;
      req_chan.a_re  <= '0;
      req_chan.a_im  <= '0;
      req_chan.b_re  <= '0;
      req_chan.b_im  <= '0;
    end else begin
      shown = make_item(req_chan.func, req_chan.a_re, req_chan.a_im,
                        req_chan.b_re, req_chan.b_im);
      load = 1'b0;
      next_valid = req_chan.valid;
      if (req_chan.valid && req_chan.ready) begin
        expected_results.push_back(alu_result(shown, coeff_regs));
        requests_sent++;
        next_valid = 1'b0;
      end
      // a request not yet taken stays on the channel unchanged
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() != 0) begin
          next_req   = request_queue.pop_front();
          next_valid = 1'b1;
          load       = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
      req_chan.valid <= next_valid;
      if (load) begin
        req_chan.func <= next_req.func;
        req_chan.a_re <= next_req.a_re;
        req_chan.a_im <= next_req.a_im;
        req_chan.b_re <= next_req.b_re;
        req_chan.b_im <= next_req.b_im;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver back-pressure
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;
  int cycle_cnt  = 0;

  always @(posedge clk) begin : result_monitor
    csa_result_t want;
    logic        next_ready;
    if (!rst_n) begin
      res_chan.ready <= 1'b0;
    end else begin
      if (res_chan.valid && res_chan.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing outstanding: y_re=%0d y_im=%0d saturated=%0b",
                 res_chan.y_re, res_chan.y_im, res_chan.saturated);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.saturated) saturated_seen++;
          if (res_chan.y_re !== want.y_re) begin
            $error("y_re: expected %0d, got %0d", want.y_re, res_chan.y_re);
            error_count++;
          end
          if (res_chan.y_im !== want.y_im) begin
            $error("y_im: expected %0d, got %0d", want.y_im, res_chan.y_im);
            error_count++;
          end
          if (res_chan.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated,
                   res_chan.saturated);
            error_count++;
          end
        end
      end

      // stall behaviour changes at random intervals between these modes:
      // always ready, mostly ready, one cycle in three, or long stalls
      cycle_cnt++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: next_ready = 1'b1;
        1: next_ready = ($urandom_range(0, 9) < 7);
        2: next_ready = (cycle_cnt % 3 == 0);
        default: begin
          if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            hold_left  = $urandom_range(1, 12);
            next_ready = 1'b0;
          end else begin
            next_ready = 1'b1;
          end
        end
      endcase
      res_chan.ready <= next_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    // reset and configuration inputs known from time zero
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;

    // coefficient values after reset
    coeff_regs.scale  = COEFF_ONE;
    coeff_regs.lambda = COEFF_ONE;
    coeff_regs.mu     = COEFF_ONE;
    coeff_regs.c_re   = COEFF_ONE;
    coeff_regs.c_im   = '0;
    settings_used     = 1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests under the reset coefficients
    // conjugate of the most negative imaginary part clips to the maximum
    request_queue.push_back(make_item(FN_CONJ, SAMPLE_MIN, SAMPLE_MIN, '0, '0));
    request_queue.push_back(make_item(FN_CONJ, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));
    // (-1)*(-1) overflows the sample range
    request_queue.push_back(make_item(FN_MUL, SAMPLE_MIN, '0, SAMPLE_MIN, '0));
    request_queue.push_back(make_item(FN_MUL, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN));
    request_queue.push_back(make_item(FN_MUL, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN));
    // rounding ties go towards plus infinity
    request_queue.push_back(make_item(FN_MUL, 16'sd1, '0, 16'sd16384, '0));
    request_queue.push_back(make_item(FN_MUL, -16'sd1, '0, 16'sd16384, '0));
    request_queue.push_back(make_item(FN_MUL, '0, '0, '0, '0));
    request_queue.push_back(make_item(FN_SCALE, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX));
    request_queue.push_back(make_item(FN_SCALE, 16'sd1, -16'sd1, '0, '0));
    request_queue.push_back(make_item(FN_SUB, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN));
    request_queue.push_back(make_item(FN_SUB, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX));
    request_queue.push_back(make_item(FN_SUB, '0, '0, '0, '0));
    request_queue.push_back(make_item(FN_ADD, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN));
    request_queue.push_back(make_item(FN_ADD, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX));
    request_queue.push_back(make_item(FN_ADD, -16'sd1, 16'sd1, 16'sd1, -16'sd1));
    request_queue.push_back(make_item(FN_LIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));
    request_queue.push_back(make_item(FN_LIN, SAMPLE_MAX, '0, SAMPLE_MIN, '0));
    request_queue.push_back(make_item(FN_CMUL, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX));
    request_queue.push_back(make_item(FN_CMUL, '0, -16'sd1, '0, '0));
    // unused opcode with busy operands still gives a zero result
    request_queue.push_back(make_item(FUNC_UNUSED, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));
    request_queue.push_back(make_item(FUNC_UNUSED, '1, '1, '1, '1));
    queue_random(200);
    wait_idle();

    // largest positive coefficients everywhere
    apply_coeffs(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX);
    queue_random(250);
    wait_idle();

    // most negative coefficients everywhere
    apply_coeffs(COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN);
    queue_random(250);
    wait_idle();

    // zero scale, a minus b, and multiply by j
    apply_coeffs('0, COEFF_ONE, COEFF_NEG_ONE, '0, COEFF_ONE);
    queue_random(250);
    wait_idle();

    // random mixes of coefficients
    for (int p = 0; p < 3; p++) begin
      apply_coeffs(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
      queue_random(250);
      wait_idle();
    end

    $display("%0d requests driven, %0d results checked (%0d saturated)",
             requests_sent, results_checked, saturated_seen);
    $display("all eight opcodes exercised under %0d coefficient settings", settings_used);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // hard stop in case the block stops responding
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
